// File: src/ppp_pkg.sv
// shared types, widths and register codes for the perspective point projection
// no dependencies
`timescale 1ns / 1ps

package ppp_pkg;

    localparam int NUM_CELLS = 33;           // quotient bits 32..0
    localparam int QW        = NUM_CELLS;
    localparam int DEN_W     = 50;           // w is positive and below 2^49
    localparam int REM_W     = 80;           // numerator magnitude scaled by 2^16
    localparam int SUB_W     = REM_W + 2;    // room for den shifted by the top bit

    localparam logic signed [49:0] W_THRESHOLD = 50'sd16777;

    localparam logic [2:0] REG_ROW1_A = 3'd0;
    localparam logic [2:0] REG_ROW1_B = 3'd1;
    localparam logic [2:0] REG_ROW2_A = 3'd2;
    localparam logic [2:0] REG_ROW2_B = 3'd3;
    localparam logic [2:0] REG_ROW4_A = 3'd4;
    localparam logic [2:0] REG_ROW4_B = 3'd5;
    localparam logic [2:0] REG_WIDTH  = 3'd6;
    localparam logic [2:0] REG_HEIGHT = 3'd7;

    localparam logic [13:0] WIDTH_RESET  = 14'd1920;
    localparam logic [13:0] HEIGHT_RESET = 14'd1080;

    typedef struct packed {
        logic signed [31:0] point_x;
        logic signed [31:0] point_y;
        logic signed [31:0] point_z;
    } point_t;

    typedef struct packed {
        logic signed [31:0] screen_x;
        logic signed [31:0] screen_y;
        logic               visible;
    } result_t;

    // state carried from one divider cell to the next, both axes side by side
    typedef struct packed {
        logic [DEN_W-1:0] den;
        logic [REM_W-1:0] rem_x;
        logic [REM_W-1:0] rem_y;
        logic [QW-1:0]    q_x;
        logic [QW-1:0]    q_y;
        logic             neg_x;
        logic             neg_y;
        logic             ovf_x;
        logic             ovf_y;
        logic             vis;
    } div_t;

endpackage

// File: src/perspective_point_projection.sv
// perspective projection of one Q16.16 point to screen coordinates
// pipeline: 4 arithmetic stages, 33 divider cells and an output register; throughput:
// one transaction per cycle while out_stall is low, set by the fully pipelined
// multiplier stages and the 33-cell division chain
// reset: rst_n clears all valid flags; matrix registers clear to 0, width to 1920,
// height to 1080; data registers are not reset
// depends on ppp_pkg and ppp_cell
`timescale 1ns / 1ps

module perspective_point_projection
    import ppp_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [63:0] cfg_data,
    input  logic        in_valid,
    output logic        in_stall,
    input  point_t      point,
    output logic        out_valid,
    input  logic        out_stall,
    output result_t     result
);

    // ------------------------------------------------------------------
    // configuration registers
    // ------------------------------------------------------------------
    logic [63:0] mat_reg [6];
    logic [13:0] width_reg;
    logic [13:0] height_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 6; i++)
            begin
                mat_reg[i] <= '0;
            end
            width_reg  <= WIDTH_RESET;
            height_reg <= HEIGHT_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_ROW1_A: mat_reg[0] <= cfg_data;
                REG_ROW1_B: mat_reg[1] <= cfg_data;
                REG_ROW2_A: mat_reg[2] <= cfg_data;
                REG_ROW2_B: mat_reg[3] <= cfg_data;
                REG_ROW4_A: mat_reg[4] <= cfg_data;
                REG_ROW4_B: mat_reg[5] <= cfg_data;
                REG_WIDTH:  width_reg  <= cfg_data[13:0];
                REG_HEIGHT: height_reg <= cfg_data[13:0];
            endcase
        end
    end

    // ------------------------------------------------------------------
    // flow control: each stage loads when it is empty or its successor moves
    // ------------------------------------------------------------------
    logic s1_valid_reg, s2_valid_reg, s3_valid_reg, s4_valid_reg, out_valid_reg;
    logic s1_rdy, s2_rdy, s3_rdy, s4_rdy, out_rdy;
    logic cell_valid [NUM_CELLS+1];
    logic cell_rdy   [NUM_CELLS+1];
    div_t cell_data  [NUM_CELLS+1];

    assign out_rdy  = !out_valid_reg || !out_stall;
    assign s4_rdy   = !s4_valid_reg || cell_rdy[0];
    assign s3_rdy   = !s3_valid_reg || s4_rdy;
    assign s2_rdy   = !s2_valid_reg || s3_rdy;
    assign s1_rdy   = !s1_valid_reg || s2_rdy;
    assign in_stall = !s1_rdy;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            s3_valid_reg  <= 1'b0;
            s4_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (s1_rdy)
            begin
                s1_valid_reg <= in_valid;
            end
            if (s2_rdy)
            begin
                s2_valid_reg <= s1_valid_reg;
            end
            if (s3_rdy)
            begin
                s3_valid_reg <= s2_valid_reg;
            end
            if (s4_rdy)
            begin
                s4_valid_reg <= s3_valid_reg;
            end
            if (out_rdy)
            begin
                out_valid_reg <= cell_valid[NUM_CELLS];
            end
        end
    end

    // ------------------------------------------------------------------
    // stage 1: nine coefficient products, floored to 24 fraction bits
    // row 0 is matrix row 1, row 1 is matrix row 2, row 2 is matrix row 4
    // ------------------------------------------------------------------
    logic signed [47:0] s1_prod_reg  [3][3];
    logic signed [31:0] s1_const_reg [3];
    logic signed [47:0] prod_next    [3][3];
    logic signed [63:0] full_prod    [3][3];

    always_comb
    begin
        for (int r = 0; r < 3; r++)
        begin
            full_prod[r][0] = $signed(mat_reg[2*r][31:0])    * point.point_x;
            full_prod[r][1] = $signed(mat_reg[2*r][63:32])   * point.point_y;
            full_prod[r][2] = $signed(mat_reg[2*r+1][31:0])  * point.point_z;
            for (int j = 0; j < 3; j++)
            begin
                // dropping the low bits of a two's complement value floors it
                prod_next[r][j] = full_prod[r][j][63:16];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && s1_rdy)
        begin
            for (int r = 0; r < 3; r++)
            begin
                s1_prod_reg[r]  <= prod_next[r];
                s1_const_reg[r] <= $signed(mat_reg[2*r+1][63:32]);
            end
        end
    end

    // ------------------------------------------------------------------
    // stage 2: row sums, visibility test, w + p1 and w - p2
    // ------------------------------------------------------------------
    logic signed [49:0] row_sum [3];
    logic signed [50:0] s2_ax_reg, s2_ay_reg;
    logic signed [49:0] s2_w_reg;
    logic               s2_vis_reg;

    always_comb
    begin
        for (int r = 0; r < 3; r++)
        begin
            row_sum[r] = 50'(s1_prod_reg[r][0]) + 50'(s1_prod_reg[r][1])
                       + 50'(s1_prod_reg[r][2]) + 50'(s1_const_reg[r]);
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_valid_reg && s2_rdy)
        begin
            s2_ax_reg  <= 51'(row_sum[2]) + 51'(row_sum[0]);
            s2_ay_reg  <= 51'(row_sum[2]) - 51'(row_sum[1]);
            s2_w_reg   <= row_sum[2];
            s2_vis_reg <= row_sum[2] > W_THRESHOLD;
        end
    end

    // ------------------------------------------------------------------
    // stage 3: scale by the half viewport sizes
    // ------------------------------------------------------------------
    logic signed [13:0] half_w, half_h;
    logic signed [63:0] s3_nx_reg, s3_ny_reg;
    logic signed [49:0] s3_w_reg;
    logic               s3_vis_reg;

    assign half_w = $signed({1'b0, width_reg[13:1]});
    assign half_h = $signed({1'b0, height_reg[13:1]});

    always_ff @(posedge clk)
    begin
        if (s2_valid_reg && s3_rdy)
        begin
            s3_nx_reg  <= 64'(s2_ax_reg) * 64'(half_w);
            s3_ny_reg  <= 64'(s2_ay_reg) * 64'(half_h);
            s3_w_reg   <= s2_w_reg;
            s3_vis_reg <= s2_vis_reg;
        end
    end

    // ------------------------------------------------------------------
    // stage 4: sign and magnitude, overflow precheck, divider setup
    // ------------------------------------------------------------------
    logic [63:0]      mag_x, mag_y;
    logic [DEN_W-1:0] den;
    logic [67:0]      den_top;
    div_t             s4_data_reg;
    div_t             s4_next;

    always_comb
    begin
        mag_x   = s3_nx_reg[63] ? 64'(-s3_nx_reg) : 64'(s3_nx_reg);
        mag_y   = s3_ny_reg[63] ? 64'(-s3_ny_reg) : 64'(s3_ny_reg);
        // hidden points still run through the chain; keep the divisor nonzero
        den     = s3_vis_reg ? DEN_W'(s3_w_reg) : DEN_W'(1);
        den_top = 68'(den) << 17;
        s4_next.den   = den;
        s4_next.rem_x = REM_W'(mag_x) << 16;
        s4_next.rem_y = REM_W'(mag_y) << 16;
        s4_next.q_x   = '0;
        s4_next.q_y   = '0;
        s4_next.neg_x = s3_nx_reg[63];
        s4_next.neg_y = s3_ny_reg[63];
        // quotient would need more than 33 bits
        s4_next.ovf_x = 68'(mag_x) >= den_top;
        s4_next.ovf_y = 68'(mag_y) >= den_top;
        s4_next.vis   = s3_vis_reg;
    end

    always_ff @(posedge clk)
    begin
        if (s3_valid_reg && s4_rdy)
        begin
            s4_data_reg <= s4_next;
        end
    end

    // ------------------------------------------------------------------
    // division chain: cell i settles quotient bit NUM_CELLS-1-i
    // ------------------------------------------------------------------
    assign cell_valid[0]        = s4_valid_reg;
    assign cell_data[0]         = s4_data_reg;
    assign cell_rdy[NUM_CELLS]  = out_rdy;

    for (genvar i = 0; i < NUM_CELLS; i++)
    begin : g_cell
        ppp_cell #(
            .BIT (NUM_CELLS - 1 - i)
        ) u_cell (
            .clk        (clk),
            .rst_n      (rst_n),
            .up_valid   (cell_valid[i]),
            .up_ready   (cell_rdy[i]),
            .up_data    (cell_data[i]),
            .down_valid (cell_valid[i+1]),
            .down_ready (cell_rdy[i+1]),
            .down_data  (cell_data[i+1])
        );
    end

    // ------------------------------------------------------------------
    // output stage: saturate, apply sign, zero hidden points
    // ------------------------------------------------------------------
    function automatic logic [31:0] finish(input logic [QW-1:0] q, input logic neg,
                                           input logic ovf);
        logic [31:0] res;
        if (ovf || q > QW'(33'h080000000))
        begin
            res = 32'h80000000;
        end
        else
        begin
            res = q[31:0];
        end
        if (!neg)
        begin
            if (res > 32'h7FFFFFFF)
            begin
                res = 32'h7FFFFFFF;
            end
        end
        else
        begin
            res = -res;
        end
        return res;
    endfunction

    div_t    last;
    result_t result_next;
    result_t result_reg;

    assign last = cell_data[NUM_CELLS];

    always_comb
    begin
        result_next.visible = last.vis;
        if (last.vis)
        begin
            result_next.screen_x = $signed(finish(last.q_x, last.neg_x, last.ovf_x));
            result_next.screen_y = $signed(finish(last.q_y, last.neg_y, last.ovf_y));
        end
        else
        begin
            result_next.screen_x = '0;
            result_next.screen_y = '0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cell_valid[NUM_CELLS] && out_rdy)
        begin
            result_reg <= result_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign result    = result_reg;

    // ------------------------------------------------------------------
    // assertions
    // ------------------------------------------------------------------
    a_hidden_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !result.visible |-> result.screen_x == 0 && result.screen_y == 0)
        else $error("hidden point with nonzero coordinates");

    a_in_to_s1: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> s1_valid_reg)
        else $error("accepted transaction lost at first stage");

    a_chain_to_out: assert property (@(posedge clk) disable iff (!rst_n)
        cell_valid[NUM_CELLS] && out_rdy |=> out_valid)
        else $error("divider result not delivered to output register");

    a_hold_chain: assert property (@(posedge clk) disable iff (!rst_n)
        s4_valid_reg && !cell_rdy[0] |=> s4_valid_reg && $stable(s4_data_reg))
        else $error("divider setup changed while chain stalled");

endmodule

// File: src/ppp_cell.sv
// one restoring-division cell: decides one quotient bit for both axes
// depends on ppp_pkg
`timescale 1ns / 1ps

module ppp_cell
    import ppp_pkg::*;
#(
    parameter int BIT = 0
)
(
    input  logic clk,
    input  logic rst_n,
    input  logic up_valid,
    output logic up_ready,
    input  div_t up_data,
    output logic down_valid,
    input  logic down_ready,
    output div_t down_data
);

    logic             valid_reg;
    div_t             data_reg;
    div_t             data_next;
    logic [SUB_W-1:0] den_sh;
    logic [SUB_W-1:0] diff_x;
    logic [SUB_W-1:0] diff_y;
    logic             ge_x;
    logic             ge_y;

    assign up_ready   = !valid_reg || down_ready;
    assign down_valid = valid_reg;
    assign down_data  = data_reg;

    always_comb
    begin
        den_sh    = SUB_W'(up_data.den) << BIT;
        ge_x      = SUB_W'(up_data.rem_x) >= den_sh;
        ge_y      = SUB_W'(up_data.rem_y) >= den_sh;
        diff_x    = SUB_W'(up_data.rem_x) - den_sh;
        diff_y    = SUB_W'(up_data.rem_y) - den_sh;
        data_next = up_data;
        if (ge_x)
        begin
            data_next.rem_x = diff_x[REM_W-1:0];
        end
        if (ge_y)
        begin
            data_next.rem_y = diff_y[REM_W-1:0];
        end
        data_next.q_x[BIT] = ge_x;
        data_next.q_y[BIT] = ge_y;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (up_ready)
        begin
            valid_reg <= up_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (up_valid && up_ready)
        begin
            data_reg <= data_next;
        end
    end

endmodule

// File: dv/perspective_point_projection_checker.sv
// checker for the perspective point projection: mirrors the config registers,
// predicts each projected point and compares it with the block output
// depends on ppp_pkg
`timescale 1ns / 1ps

module perspective_point_projection_checker
    import ppp_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [63:0] cfg_data,
    input  logic        in_valid,
    input  logic        in_stall,
    input  point_t      point,
    input  logic        out_valid,
    input  logic        out_stall,
    input  result_t     result,
    output int          fail_count,
    output int          pending
);

    logic [63:0] matrix_reg [0:5];
    logic [13:0] width_reg;
    logic [13:0] height_reg;
    result_t     projected_q[$];

    function automatic logic signed [63:0] floor16(input logic signed [63:0] v);
        return v >>> 16;
    endfunction

    function automatic logic signed [63:0] coef_word(input int r, input bit hi);
        logic [63:0] v;
        v = matrix_reg[r];
        return hi ? 64'(signed'(v[63:32])) : 64'(signed'(v[31:0]));
    endfunction

    function automatic logic signed [63:0] row_sum(input int r, input point_t p);
        logic signed [63:0] acc;
        acc = floor16(coef_word(r, 0) * 64'(p.point_x));
        acc += floor16(coef_word(r, 1) * 64'(p.point_y));
        acc += floor16(coef_word(r + 1, 0) * 64'(p.point_z));
        acc += coef_word(r + 1, 1);
        return acc;
    endfunction

    // trunc(num * 2^16 / den) saturated to 32-bit signed
    function automatic logic signed [31:0] scale_div(input logic signed [127:0] num,
                                                     input logic signed [127:0] den);
        logic signed [127:0] q;
        q = (num <<< 16) / den;
        if (q > 128'sd2147483647)
            return 32'sh7fffffff;
        if (q < -128'sd2147483648)
            return 32'sh80000000;
        return q[31:0];
    endfunction

    function automatic result_t project_point(input point_t p);
        result_t r;
        logic signed [63:0] w, p1, p2, hw, hh;
        r = '0;
        w = row_sum(REG_ROW4_A, p);
        if (w > 64'sd16777)
        begin
            p1 = row_sum(REG_ROW1_A, p);
            p2 = row_sum(REG_ROW2_A, p);
            hw = 64'(width_reg >> 1);
            hh = 64'(height_reg >> 1);
            r.screen_x = scale_div(128'(hw) * 128'(w + p1), 128'(w));
            r.screen_y = scale_div(128'(hh) * 128'(w - p2), 128'(w));
            r.visible  = 1'b1;
        end
        return r;
    endfunction

    assign pending = projected_q.size();

    always @(posedge clk or negedge rst_n)
    begin
        result_t exp_r;
        if (!rst_n)
        begin
            for (int i = 0; i < 6; i++)
                matrix_reg[i] <= '0;
            width_reg  <= WIDTH_RESET;
            height_reg <= HEIGHT_RESET;
            fail_count <= 0;
            projected_q.delete();
        end
        else
        begin
            if (in_valid && !in_stall)
                projected_q.push_back(project_point(point));
            if (out_valid && !out_stall)
            begin
                if (projected_q.size() == 0)
                begin
                    if (fail_count < 10)
                        $display("unexpected result %h", result);
                    fail_count <= fail_count + 1;
                end
                else
                begin
                    exp_r = projected_q.pop_front();
                    if (exp_r.screen_x !== result.screen_x
                        || exp_r.screen_y !== result.screen_y
                        || exp_r.visible !== result.visible)
                    begin
                        if (fail_count < 10)
                            $display("mismatch: expected x=%h y=%h v=%b got x=%h y=%h v=%b",
                                     exp_r.screen_x, exp_r.screen_y, exp_r.visible,
                                     result.screen_x, result.screen_y, result.visible);
                        fail_count <= fail_count + 1;
                    end
                end
            end
            if (cfg_we)
            begin
                if (cfg_index == REG_WIDTH)
                    width_reg <= cfg_data[13:0];
                else if (cfg_index == REG_HEIGHT)
                    height_reg <= cfg_data[13:0];
                else
                    matrix_reg[cfg_index] <= cfg_data;
            end
        end
    end

endmodule

// File: dv/perspective_point_projection_test.sv
// top of the perspective point projection testbench: clock, reset, config phases,
// point stimulus with random gaps, output stalls, watchdog and verdict
// depends on ppp_pkg, the block and perspective_point_projection_checker
`timescale 1ns / 1ps

module perspective_point_projection_test
    import ppp_pkg::*;
();

    localparam int LATENCY    = 38;
    localparam int WATCHDOG   = 20000;
    localparam int PHASES     = 6;
    localparam int PHASE_PTS  = 200;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_we = 1'b0;
    logic [2:0]  cfg_index = '0;
    logic [63:0] cfg_data = '0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    point_t      point = '0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    result_t     result;
    int          fail_count;
    int          pending;
    int          idle_cycles = 0;

    always #5 clk = ~clk;

    perspective_point_projection dut (
        .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_index(cfg_index),
        .cfg_data(cfg_data), .in_valid(in_valid), .in_stall(in_stall), .point(point),
        .out_valid(out_valid), .out_stall(out_stall), .result(result)
    );

    perspective_point_projection_checker checker_inst (
        .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_index(cfg_index),
        .cfg_data(cfg_data), .in_valid(in_valid), .in_stall(in_stall), .point(point),
        .out_valid(out_valid), .out_stall(out_stall), .result(result),
        .fail_count(fail_count), .pending(pending)
    );

    // mostly short gaps, now and then a long one
    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50)
            return 0;
        if (r < 95)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // receiver stalls: quiet stretches alternate with busy ones
    always @(negedge clk)
    begin
        if (!rst_n || ($urandom_range(0, 255) < 40))
            out_stall <= 1'b0;
        else if ($urandom_range(0, 3) == 0)
            out_stall <= (gap_len() > 0);
    end

    // watchdog on cycles with no transaction on either channel
    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall) || !rst_n)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG)
        begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    task automatic write_reg(input logic [2:0] idx, input logic [63:0] data);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(negedge clk);
        cfg_we    <= 1'b0;
    endtask

    // hold valid until the transaction is taken, then maybe idle
    task automatic send_point(input point_t p);
        int g;
        point    <= p;
        in_valid <= 1'b1;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        @(negedge clk);
        g = gap_len();
        if (g > 0)
        begin
            in_valid <= 1'b0;
            repeat (g) @(negedge clk);
        end
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        @(negedge clk);
        while (pending != 0)
            @(negedge clk);
        repeat (LATENCY + 4) @(negedge clk);
    endtask

    function automatic logic [31:0] q824(input int milli);
        return 32'(longint'(milli) * 64'sd16777216 / 1000);
    endfunction

    function automatic logic [31:0] rand_word(input int mode);
        case (mode)
            0: return $urandom();
            1: return 32'(signed'($urandom_range(0, 8 << 16)) - (4 << 16));
            default: return 32'(signed'($urandom_range(0, 1 << 24)) - (1 << 23));
        endcase
    endfunction

    // typical camera matrix with random perturbation, or fully random words
    task automatic set_matrix(input int mode);
        logic [31:0] m [0:11];
        for (int i = 0; i < 12; i++)
            m[i] = (mode == 0) ? $urandom() : rand_word(2);
        if (mode != 0)
        begin
            m[0]  = q824(1000);
            m[5]  = q824(1000);
            m[10] = q824(1000);   // w follows z
            m[11] = 32'(signed'($urandom_range(0, 1 << 25)) - (1 << 24));
        end
        for (int r = 0; r < 6; r++)
            write_reg(3'(r), {m[2 * r + 1], m[2 * r]});
    endtask

    initial
    begin
        point_t p;
        logic [31:0] ext [0:3];
        int mode;
        ext[0] = 32'h8000_0000;
        ext[1] = 32'h7fff_ffff;
        ext[2] = 32'h0000_0000;
        ext[3] = 32'hffff_ffff;
        repeat (10) @(negedge clk);
        rst_n <= 1'b1;

        // reset matrix: w is zero, every point invisible
        send_point('{32'sh0001_0000, 32'sh0002_0000, 32'sh0003_0000});

        // directed: w threshold edges, extremes of coordinates and coefficients
        drain();
        set_matrix(1);
        write_reg(REG_ROW4_A, 64'd0);
        write_reg(REG_ROW4_B, {32'd16777, 32'd0});    // w exactly at threshold
        send_point('{32'sh0001_0000, 32'sh0001_0000, 32'sh0001_0000});
        drain();
        write_reg(REG_ROW4_B, {32'd16778, 32'd0});    // just above threshold
        send_point('{32'sh0001_0000, 32'sh0001_0000, 32'sh0001_0000});
        send_point('{32'sh7fff_ffff, 32'sh8000_0000, 32'sh0});  // saturating quotient
        send_point('{32'sh8000_0000, 32'sh7fff_ffff, 32'sh0});
        drain();
        for (int i = 0; i < 6; i++)
            write_reg(3'(i), {32'h8000_0000, 32'h7fff_ffff});
        for (int a = 0; a < 4; a++)
            for (int b = 0; b < 4; b += 3)
                send_point('{ext[a], ext[b], ext[3 - a]});
        drain();
        write_reg(REG_WIDTH, 64'd0);     // zero half sizes
        write_reg(REG_HEIGHT, 64'd1);
        set_matrix(1);
        send_point('{32'sh0001_0000, 32'sh0002_0000, 32'sh0004_0000});
        drain();
        write_reg(REG_WIDTH, 64'h3fff);  // above range
        write_reg(REG_HEIGHT, 64'hffff_ffff_ffff_ffff);
        send_point('{32'sh0001_0000, 32'sh0002_0000, 32'sh0004_0000});
        send_point('{32'shfff0_0000, 32'sh0010_0000, 32'sh0000_8000});

        // random phases, sizes at the legal extremes in the first two phases, then random
        for (int ph = 0; ph < PHASES; ph++)
        begin
            drain();
            set_matrix(ph % 3 == 2 ? 0 : 1);
            write_reg(REG_WIDTH, ph == 0 ? 64'd1 : ph == 1 ? 64'd8192
                                                 : 64'($urandom_range(1, 8192)));
            write_reg(REG_HEIGHT, ph == 0 ? 64'd8192 : ph == 1 ? 64'd1
                                                    : 64'($urandom_range(1, 8192)));
            for (int n = 0; n < PHASE_PTS; n++)
            begin
                mode = ($urandom_range(0, 9) == 0) ? 0 : 1;
                p.point_x = rand_word(mode);
                p.point_y = rand_word(mode);
                p.point_z = ($urandom_range(0, 9) == 0) ? rand_word(0)
                          : 32'(signed'($urandom_range(1 << 12, 64 << 16)));
                send_point(p);
            end
        end
        drain();

        if (fail_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

// File: filelist.f
src/ppp_pkg.sv
src/ppp_cell.sv
src/perspective_point_projection.sv
dv/perspective_point_projection_checker.sv
dv/perspective_point_projection_test.sv
